@@ rtl/fcpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpi_pkg: shared types and constants of the fly camera pose integrator
// Sequencer states, register map, angle limits and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package fcpi_pkg;

	localparam int SINE_TABLE_ENTRIES = 256;
	localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
	localparam int PH_W = $clog2(4 * SINE_TABLE_ENTRIES);

	// heading * 4N / 23040, as a multiply by a rounded-up reciprocal; the
	// error stays below the smallest nonzero fraction, so the floor is exact
	localparam int PHASE_SHIFT = 30;
	localparam logic [63:0] PHASE_RECIP =
		(64'(4 * SINE_TABLE_ENTRIES) * (64'd1 << PHASE_SHIFT) + 64'd23039) / 64'd23040;

	localparam logic [14:0] FULL_CIRCLE = 15'd23040;
	localparam logic signed [13:0] PITCH_LIMIT = 14'sd5760;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [15:0] SPEED_RESET = 16'd640;
	localparam logic [7:0] GAIN_RESET = 8'd90;

	// register index, taken from paddr[2]
	localparam logic REG_SPEED = 1'b0;
	localparam logic REG_GAIN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PHASE,
		ST_TRIG,
		ST_RX1,
		ST_RX2,
		ST_RY1,
		ST_RY2,
		ST_SX,
		ST_SY,
		ST_SZ,
		ST_DH,
		ST_DP,
		ST_PIT,
		ST_DONE
	} state_t;

	typedef logic [15:0] sine_lut_t [SINE_TABLE_ENTRIES];

	// sin(90 deg * i / N) in Q0.16 from an eight-term integer Taylor series
	function automatic sine_lut_t build_sine_lut();
		sine_lut_t lut;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] r;
		for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
			x = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_ENTRIES;
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			term = ((term * x2) >> 30) / 64'd6;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd210;
			sum = sum - $signed(term);
			if (sum < 0) begin
				sum = 64'sd0;
			end
			r = ($unsigned(sum) + 64'd8192) >> 14;
			lut[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

@@ rtl/fly_camera_pose_integrator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fly_camera_pose_integrator_top: fly camera pose integrator
// Integrates velocity commands into a Q16.16 position and pointer axis
// changes into heading and pitch, one tick per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_ stream: five Q1.15 axes and a Q0.16 time
//   step in s_tdata, the rotate flag in s_tuser. Each item yields exactly one
//   pose item on the m_ stream.
//   All arithmetic runs through one shared signed multiplier (34 x 33 bits)
//   under a sequencer: work states ST_PHASE to ST_PIT, of which ST_TRIG reads
//   the sine table, then ST_DONE loads the output register. s_tready is high
//   only while the sequencer is idle, so a new item is taken only once the
//   previous one has been loaded into the output register.
//   The output register holds a result while the receiver stalls; the next
//   item is already accepted and worked on, and the sequencer waits in its
//   last step only if the previous result is still not taken.
//   Registers (APB): translation_speed at 0x0, rotation_gain at 0x4; write
//   them only while the block is idle.
//   Reset clears position, angles and previous pointer values, marks the next
//   tick as the first one and restores the register defaults. The sine table
//   is constant logic and needs no fill.
// ----------------------------------------------------------------------------
module fly_camera_pose_integrator_top
	import fcpi_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	// axis_forward, axis_side, axis_up, axis_turn, axis_tilt, time_step
	input  logic [95:0]  s_tdata,
	// rotate_enable
	input  logic         s_tuser,
	// result items
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_heading, out_pitch, 3 zero bits
	output logic [127:0] m_tdata,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	state_t state_q, state_d;

	logic [15:0] speed_q;
	logic [7:0]  gain_q;

	logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic [14:0]        heading_q;
	logic signed [13:0] pitch_q;
	logic signed [15:0] last_turn_q, last_tilt_q;
	logic               first_tick_q;
	logic               m_tvalid_q;
	logic [127:0]       m_tdata_q;

	// latched item
	logic signed [15:0] vx_q, vy_q, vz_q;
	logic [15:0]        dt_q;
	logic               rot_q;
	logic signed [16:0] dturn_q, dtilt_q;

	// shared multiplier and working registers
	logic signed [33:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [66:0] mul_p;
	logic signed [66:0] prod_q;
	logic signed [66:0] acc_q;
	logic signed [17:0] sin_q, cos_q;
	logic [31:0]        ds_q;
	logic signed [33:0] rx_q, ry_q;
	logic               neg_q;
	logic               neg_d;

	logic in_acc;
	logic out_load;
	logic cfg_we;

	assign in_acc = s_tvalid && s_tready;
	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	always_comb begin
		unique case (paddr[2])
			REG_SPEED: prdata = {16'd0, speed_q};
			REG_GAIN:  prdata = {24'd0, gain_q};
			default:   prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// trig: phase index from the product, quadrant by compare
	// ------------------------------------------------------------------
	logic [PH_W-1:0]    phase;
	logic [1:0]         quad;
	logic [IDX_W-1:0]   rem;
	logic [IDX_W:0]     rem_n;
	logic signed [17:0] val_r, val_n, sin_d, cos_d;

	always_comb begin
		phase = prod_q[PHASE_SHIFT +: PH_W];
		priority if (phase >= PH_W'(3 * SINE_TABLE_ENTRIES)) begin
			quad = 2'd3;
			rem = IDX_W'(phase - PH_W'(3 * SINE_TABLE_ENTRIES));
		end else if (phase >= PH_W'(2 * SINE_TABLE_ENTRIES)) begin
			quad = 2'd2;
			rem = IDX_W'(phase - PH_W'(2 * SINE_TABLE_ENTRIES));
		end else if (phase >= PH_W'(SINE_TABLE_ENTRIES)) begin
			quad = 2'd1;
			rem = IDX_W'(phase - PH_W'(SINE_TABLE_ENTRIES));
		end else begin
			quad = 2'd0;
			rem = IDX_W'(phase);
		end
		rem_n = (IDX_W + 1)'(SINE_TABLE_ENTRIES) - {1'b0, rem};
		val_r = $signed({2'b00, SINE_LUT[rem]});
		// the quarter point is exactly one
		if (rem_n == (IDX_W + 1)'(SINE_TABLE_ENTRIES)) begin
			val_n = 18'sd65536;
		end else begin
			val_n = $signed({2'b00, SINE_LUT[rem_n[IDX_W-1:0]]});
		end
		unique case (quad)
			2'd0: begin
				sin_d = val_r;
				cos_d = val_n;
			end
			2'd1: begin
				sin_d = val_n;
				cos_d = -val_r;
			end
			2'd2: begin
				sin_d = -val_r;
				cos_d = -val_n;
			end
			default: begin
				sin_d = -val_n;
				cos_d = val_r;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// position update: round the scaled product and add with saturation
	// ------------------------------------------------------------------
	logic [64:0]        pos_sum;
	logic [25:0]        pos_mag;
	logic signed [26:0] pos_inc;
	logic signed [31:0] pos_old;
	logic signed [32:0] pos_wide;
	logic signed [31:0] pos_new;

	always_comb begin
		pos_sum = prod_q[64:0] + (65'd1 << 38);
		pos_mag = pos_sum[64:39];
		pos_inc = neg_q ? -$signed({1'b0, pos_mag}) : $signed({1'b0, pos_mag});
		unique case (state_q)
			ST_SY:   pos_old = pos_x_q;
			ST_SZ:   pos_old = pos_y_q;
			default: pos_old = pos_z_q;
		endcase
		pos_wide = {pos_old[31], pos_old} + {{6{pos_inc[26]}}, pos_inc};
		if (pos_wide[32] != pos_wide[31]) begin
			pos_new = pos_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			pos_new = pos_wide[31:0];
		end
	end

	// ------------------------------------------------------------------
	// angle update: gain * difference / 512, heading wrap, pitch clamp
	// ------------------------------------------------------------------
	logic signed [24:0] ang_prod;
	logic [24:0]        ang_mag;
	logic [24:0]        ang_sum;
	logic [15:0]        ang_rnd;
	logic signed [17:0] ang_delta;
	logic signed [17:0] head_a, head_b, head_c;
	logic signed [17:0] pit_a;
	logic signed [13:0] pit_new;

	always_comb begin
		ang_prod = prod_q[24:0];
		ang_mag = ang_prod[24] ? $unsigned(-ang_prod) : $unsigned(ang_prod);
		ang_sum = ang_mag + 25'd256;
		ang_rnd = ang_sum[24:9];
		ang_delta = ang_prod[24] ? -$signed({2'b00, ang_rnd}) : $signed({2'b00, ang_rnd});

		head_a = $signed({3'b000, heading_q}) - ang_delta;
		if (head_a >= $signed({3'b000, FULL_CIRCLE})) begin
			head_b = head_a - $signed({3'b000, FULL_CIRCLE});
		end else if (head_a < 0) begin
			head_b = head_a + $signed({3'b000, FULL_CIRCLE});
		end else begin
			head_b = head_a;
		end
		// a turn of more than a full circle needs a second correction
		if (head_b >= $signed({3'b000, FULL_CIRCLE})) begin
			head_c = head_b - $signed({3'b000, FULL_CIRCLE});
		end else if (head_b < 0) begin
			head_c = head_b + $signed({3'b000, FULL_CIRCLE});
		end else begin
			head_c = head_b;
		end

		pit_a = {{4{pitch_q[13]}}, pitch_q} + ang_delta;
		if (pit_a > $signed({{4{PITCH_LIMIT[13]}}, PITCH_LIMIT})) begin
			pit_new = PITCH_LIMIT;
		end else if (pit_a < -$signed({{4{PITCH_LIMIT[13]}}, PITCH_LIMIT})) begin
			pit_new = -PITCH_LIMIT;
		end else begin
			pit_new = pit_a[13:0];
		end
	end

	// ------------------------------------------------------------------
	// sequencer: next state and multiplier operands
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		mul_a = 34'sd0;
		mul_b = 33'sd0;
		neg_d = neg_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_PHASE;
				end
			end
			ST_PHASE: begin
				mul_a = $signed({19'd0, heading_q});
				mul_b = $signed(PHASE_RECIP[32:0]);
				state_d = ST_TRIG;
			end
			ST_TRIG: begin
				mul_a = $signed({18'd0, dt_q});
				mul_b = $signed({17'd0, speed_q});
				state_d = ST_RX1;
			end
			ST_RX1: begin
				mul_a = 34'(vx_q);
				mul_b = 33'(cos_q);
				state_d = ST_RX2;
			end
			ST_RX2: begin
				mul_a = 34'(vy_q);
				mul_b = 33'(sin_q);
				state_d = ST_RY1;
			end
			ST_RY1: begin
				mul_a = 34'(vx_q);
				mul_b = 33'(sin_q);
				state_d = ST_RY2;
			end
			ST_RY2: begin
				mul_a = 34'(vy_q);
				mul_b = 33'(cos_q);
				state_d = ST_SX;
			end
			ST_SX: begin
				mul_a = rx_q[33] ? -rx_q : rx_q;
				mul_b = $signed({1'b0, ds_q});
				neg_d = rx_q[33];
				state_d = ST_SY;
			end
			ST_SY: begin
				mul_a = ry_q[33] ? -ry_q : ry_q;
				mul_b = $signed({1'b0, ds_q});
				neg_d = ry_q[33];
				state_d = ST_SZ;
			end
			ST_SZ: begin
				mul_a = $signed({1'b0, (vz_q[15] ? 17'(-vz_q) : 17'(vz_q)), 16'd0});
				mul_b = $signed({1'b0, ds_q});
				neg_d = vz_q[15];
				state_d = ST_DH;
			end
			ST_DH: begin
				mul_a = $signed({26'd0, gain_q});
				mul_b = 33'(dturn_q);
				state_d = ST_DP;
			end
			ST_DP: begin
				mul_a = $signed({26'd0, gain_q});
				mul_b = 33'(dtilt_q);
				state_d = ST_PIT;
			end
			ST_PIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------
	// pose state, registers and output handshake
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			gain_q <= GAIN_RESET;
			pos_x_q <= 32'sd0;
			pos_y_q <= 32'sd0;
			pos_z_q <= 32'sd0;
			heading_q <= 15'd0;
			pitch_q <= 14'sd0;
			last_turn_q <= 16'sd0;
			last_tilt_q <= 16'sd0;
			first_tick_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (paddr[2])
					REG_SPEED: speed_q <= pwdata[15:0];
					REG_GAIN:  gain_q <= pwdata[7:0];
					default:   speed_q <= speed_q;
				endcase
			end
			if (in_acc) begin
				last_turn_q <= $signed(s_tdata[63:48]);
				last_tilt_q <= $signed(s_tdata[79:64]);
				first_tick_q <= 1'b0;
			end
			unique case (state_q)
				ST_SY:   pos_x_q <= pos_new;
				ST_SZ:   pos_y_q <= pos_new;
				ST_DH:   pos_z_q <= pos_new;
				ST_DP: begin
					if (rot_q) begin
						heading_q <= head_c[14:0];
					end
				end
				ST_PIT: begin
					if (rot_q) begin
						pitch_q <= pit_new;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		neg_q <= neg_d;
		if (in_acc) begin
			vx_q <= $signed(s_tdata[15:0]);
			vy_q <= $signed(s_tdata[31:16]);
			vz_q <= $signed(s_tdata[47:32]);
			dt_q <= s_tdata[95:80];
			rot_q <= s_tuser;
			// the first tick sees no pointer motion
			if (first_tick_q) begin
				dturn_q <= 17'sd0;
				dtilt_q <= 17'sd0;
			end else begin
				dturn_q <= 17'($signed(s_tdata[63:48])) - 17'(last_turn_q);
				dtilt_q <= 17'($signed(s_tdata[79:64])) - 17'(last_tilt_q);
			end
		end
		unique case (state_q)
			ST_TRIG: begin
				sin_q <= sin_d;
				cos_q <= cos_d;
			end
			ST_RX1:  ds_q <= prod_q[31:0];
			ST_RX2:  acc_q <= prod_q;
			ST_RY1:  rx_q <= 34'(acc_q - prod_q);
			ST_RY2:  acc_q <= prod_q;
			ST_SX:   ry_q <= 34'(acc_q + prod_q);
			default: begin
			end
		endcase
		if (out_load) begin
			m_tdata_q <= {3'b000, pitch_q, heading_q, pos_z_q, pos_y_q, pos_x_q};
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		heading_q < FULL_CIRCLE)
		else $error("heading left 0..23039");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pitch_q <= PITCH_LIMIT) && (pitch_q >= -PITCH_LIMIT))
		else $error("pitch beyond clamp");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_PHASE))
		else $error("accepted item did not start the sequence");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without finishing an item");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: fly camera pose integrator
// Drives tick items on the input stream under several register settings and
// idle patterns, predicts each pose item with a bit-exact model of the
// integrator and compares every result field by field against the oldest
// expected pose.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned QW = fcpi_pkg::SINE_TABLE_ENTRIES;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint CIRCLE_UNITS = 23040;
	localparam longint PITCH_MAX = 5760;
	localparam int STUCK_LIMIT = 2000;

	typedef struct {
		logic signed [15:0] fwd;
		logic signed [15:0] side;
		logic signed [15:0] up;
		logic signed [15:0] turn;
		logic signed [15:0] tilt;
		logic [15:0]        dt;
		logic               rot;
	} tick_t;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [14:0]        heading;
		logic signed [13:0] pitch;
	} pose_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// axis_forward, axis_side, axis_up, axis_turn, axis_tilt, time_step
	logic [95:0]  s_tdata = '0;
	// rotate_enable
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// out_pos_x, out_pos_y, out_pos_z, out_heading, out_pitch, 3 zero bits
	logic [127:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// pose model state
	logic [15:0]        quarter_wave [QW];
	logic signed [31:0] cam_x, cam_y, cam_z;
	logic [14:0]        head_ang;
	logic signed [13:0] pitch_ang;
	logic signed [15:0] prev_turn, prev_tilt;
	logic               first_tick_pend;
	logic [15:0]        trans_speed;
	logic [7:0]         turn_gain;

	tick_t tick_queue [$];
	pose_t pose_queue [$];
	tick_t cur_tick;
	logic  tick_taken = 1'b0;
	int    src_idle_pct = 0;
	int    sink_stall_pct = 0;
	int    mismatches = 0;
	int    stuck_cycles = 0;
	logic signed [15:0] walk_turn = '0, walk_tilt = '0;

	fly_camera_pose_integrator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// quarter-wave sine in Q0.16 from an eight-term integer Taylor series
	function automatic void build_quarter_wave();
		longint unsigned x, x2, term, r;
		longint sum;
		for (int i = 0; i < QW; i++) begin
			x = (HALF_PI_Q30 * longint'(i)) / QW;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int k = 1; k <= 7; k++) begin
				term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			r = ($unsigned(sum) + 64'd8192) >> 14;
			quarter_wave[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
		end
	endfunction

	function automatic void reset_pose_model();
		build_quarter_wave();
		cam_x = '0;
		cam_y = '0;
		cam_z = '0;
		head_ang = '0;
		pitch_ang = '0;
		prev_turn = '0;
		prev_tilt = '0;
		first_tick_pend = 1'b1;
		trans_speed = 16'd640;
		turn_gain = 8'd90;
	endfunction

	function automatic longint sine_phase(int unsigned ph);
		int unsigned r, k;
		longint mag;
		r = ph % QW;
		k = ((ph / QW) % 2 == 1) ? QW - r : r;
		mag = (k >= QW) ? 64'sd65536 : longint'(quarter_wave[k]);
		return ((ph / QW) % 4 >= 2) ? -mag : mag;
	endfunction

	// Q31 rotated command -> Q16.16 increment, rounded half away from zero
	function automatic longint scaled_step(longint v, logic [15:0] dt);
		logic [127:0] m;
		logic neg;
		neg = v < 0;
		m = 128'(neg ? -v : v);
		m = m * dt * trans_speed;
		m = (m + (128'd1 << 38)) >> 39;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint round9(longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + 256) >>> 9;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [31:0] saturate32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	task automatic integrate_tick(input tick_t t, output pose_t p);
		int unsigned ph;
		longint sn, cs, rx, ry, dh, dp, h, pt;
		ph = (32'(head_ang) * (4 * QW)) / 32'd23040;
		sn = sine_phase(ph);
		cs = sine_phase((ph + QW) % (4 * QW));
		rx = longint'(t.fwd) * cs - longint'(t.side) * sn;
		ry = longint'(t.fwd) * sn + longint'(t.side) * cs;
		cam_x = saturate32(longint'(cam_x) + scaled_step(rx, t.dt));
		cam_y = saturate32(longint'(cam_y) + scaled_step(ry, t.dt));
		cam_z = saturate32(longint'(cam_z) + scaled_step(longint'(t.up) * 65536, t.dt));
		// first tick sees no pointer change
		if (first_tick_pend) begin
			prev_turn = t.turn;
			prev_tilt = t.tilt;
		end
		if (t.rot) begin
			dh = round9(longint'(turn_gain) * (longint'(t.turn) - longint'(prev_turn)));
			dp = round9(longint'(turn_gain) * (longint'(t.tilt) - longint'(prev_tilt)));
			h = longint'(head_ang) - dh;
			pt = longint'(pitch_ang) + dp;
			for (int n = 0; n < 2; n++) begin
				if (h >= CIRCLE_UNITS) begin
					h = h - CIRCLE_UNITS;
				end else if (h < 0) begin
					h = h + CIRCLE_UNITS;
				end
			end
			if (pt > PITCH_MAX) begin
				pt = PITCH_MAX;
			end else if (pt < -PITCH_MAX) begin
				pt = -PITCH_MAX;
			end
			head_ang = h[14:0];
			pitch_ang = pt[13:0];
		end
		prev_turn = t.turn;
		prev_tilt = t.tilt;
		first_tick_pend = 1'b0;
		p.pos_x = cam_x;
		p.pos_y = cam_y;
		p.pos_z = cam_z;
		p.heading = head_ang;
		p.pitch = pitch_ang;
	endtask

	function automatic void report_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// driver: present the next item once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
			if (!s_tvalid || tick_taken) begin
				tick_taken = 1'b0;
				if (tick_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_tick = tick_queue.pop_front();
					s_tdata <= {cur_tick.dt, cur_tick.tilt, cur_tick.turn,
						cur_tick.up, cur_tick.side, cur_tick.fwd};
					s_tuser <= cur_tick.rot;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: predict on input acceptance, check on output acceptance
	always @(posedge clk) begin : monitor
		pose_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				integrate_tick(cur_tick, want);
				pose_queue.push_back(want);
				tick_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.pos_x = m_tdata[31:0];
				got.pos_y = m_tdata[63:32];
				got.pos_z = m_tdata[95:64];
				got.heading = m_tdata[110:96];
				got.pitch = m_tdata[124:111];
				if (pose_queue.size() == 0) begin
					$display("%0t ns: unexpected pose item, expected none got %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = pose_queue.pop_front();
					report_field("out_pos_x", want.pos_x, got.pos_x);
					report_field("out_pos_y", want.pos_y, got.pos_y);
					report_field("out_pos_z", want.pos_z, got.pos_z);
					report_field("out_heading", want.heading, got.heading);
					report_field("out_pitch", want.pitch, got.pitch);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic queue_tick(input logic signed [15:0] fwd, input logic signed [15:0] side,
			input logic signed [15:0] up, input logic signed [15:0] turn,
			input logic signed [15:0] tilt, input logic [15:0] dt, input logic rot);
		tick_t t;
		t.fwd = fwd;
		t.side = side;
		t.up = up;
		t.turn = turn;
		t.tilt = tilt;
		t.dt = dt;
		t.rot = rot;
		tick_queue.push_back(t);
	endtask

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3, 4: return 16'($urandom_range(512)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	// pointer sometimes moves smoothly, mostly jumps
	function automatic logic signed [15:0] step_pointer(logic signed [15:0] cur);
		case ($urandom_range(9))
			0, 1, 2, 3: return 16'($urandom);
			4: return 16'h8000;
			5: return 16'h7FFF;
			default: return cur + (16'($urandom_range(2048)) - 16'd1024);
		endcase
	endfunction

	function automatic logic [15:0] rand_step();
		case ($urandom_range(9))
			0, 1: return 16'hFFFF;
			2: return 16'h0000;
			3, 4, 5: return 16'($urandom_range(2000));
			default: return 16'($urandom);
		endcase
	endfunction

	// dashes push one way at full step to drive the position into saturation
	task automatic queue_random_ticks(input int count, input int dash_pct,
			input int rot_pct, input logic drift_neg);
		tick_t t;
		for (int n = 0; n < count; n++) begin
			walk_turn = step_pointer(walk_turn);
			walk_tilt = step_pointer(walk_tilt);
			t.turn = walk_turn;
			t.tilt = walk_tilt;
			t.side = rand_axis();
			if ($urandom_range(99) < dash_pct) begin
				t.fwd = drift_neg ? 16'h8000 : 16'h7FFF;
				t.up = drift_neg ? 16'h8000 : 16'h7FFF;
				t.dt = 16'hFFFF;
				t.rot = 1'b0;
			end else begin
				t.fwd = rand_axis();
				t.up = rand_axis();
				t.dt = rand_step();
				t.rot = ($urandom_range(99) < rot_pct);
			end
			tick_queue.push_back(t);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == fcpi_pkg::REG_SPEED) begin
			trans_speed = value[15:0];
		end else begin
			turn_gain = value[7:0];
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (tick_queue.size() != 0 || s_tvalid || pose_queue.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin : stimulus
		int speed_set [8];
		int gain_set [8];
		int dash_set [8];
		int rot_set [8];
		logic drift_set [8];
		reset_pose_model();
		speed_set = '{640, 65535, 0, 1, $urandom_range(65535), 65535,
			$urandom_range(65535), 65535};
		gain_set = '{90, 255, 0, 1, 255, $urandom_range(255), 200, 128};
		dash_set = '{10, 70, 20, 20, 30, 70, 20, 70};
		rot_set = '{50, 10, 60, 50, 40, 10, 80, 10};
		drift_set = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

		// directed ticks under reset register values
		queue_tick(32767, -32768, 32767, 32767, -32768, 65535, 1);  // first tick
		queue_tick(-32768, 32767, -32768, -1, -1, 65535, 1);        // to 90 deg
		queue_tick(32767, 16384, 0, -1, 32767, 40000, 0);
		queue_tick(-20000, 12345, 1, -32768, -32768, 65535, 1);     // 180 deg, pitch low
		queue_tick(32767, 32767, -1, 32767, -32768, 1, 1);          // back to 0
		queue_tick(0, 0, 0, 32767, 0, 0, 0);
		queue_tick(-32768, -32768, 32767, -32768, 32767, 65535, 1);
		queue_tick(100, -100, 0, 32767, 32767, 65535, 0);
		queue_tick(32767, 0, -32768, -32768, 32767, 65535, 1);      // wrap at full circle
		queue_tick(0, 32767, 0, 32767, 32767, 65535, 1);            // wrap below zero
		queue_tick(0, 0, 0, 0, 0, 0, 0);
		queue_tick(12345, -23456, 32767, -32768, 0, 65535, 1);      // to 270 deg
		queue_tick(-32768, 0, 0, 0, 0, 65535, 0);
		queue_tick(0, 0, 0, 0, 0, 3, 0);
		queue_tick(5000, 7000, -9000, 128, -128, 65535, 1);         // rounding ties
		queue_tick(0, 0, 0, 0, 0, 2, 1);
		queue_tick(0, 0, 0, -32768, 32767, 65535, 0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			write_reg(fcpi_pkg::REG_SPEED, {16'($urandom), 16'(speed_set[ph])});
			write_reg(fcpi_pkg::REG_GAIN, {24'($urandom), 8'(gain_set[ph])});
			case (ph % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 49;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 49;
				end
				default: begin
					src_idle_pct = 34;
					sink_stall_pct = 34;
				end
			endcase
			queue_random_ticks(153, dash_set[ph], rot_set[ph], drift_set[ph]);
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
